[rtl/qrs_pkg.sv]
package qrs_pkg;

    // word limits
    localparam logic [63:0] WMAX = 64'h7fff_ffff_ffff_ffff;
    localparam logic [63:0] WMIN = 64'h8000_0000_0000_0000;
    localparam logic [63:0] ONE_Q = 64'h0000_0001_0000_0000;

    // result status codes
    localparam logic [1:0] ST_OK = 2'd0;
    localparam logic [1:0] ST_NC = 2'd1;
    localparam logic [1:0] ST_ZD = 2'd2;

    // register indexes on the configuration port
    localparam logic [1:0] REG_TOL = 2'd0;
    localparam logic [1:0] REG_MAXIT = 2'd1;
    localparam logic [1:0] REG_START_U = 2'd2;
    localparam logic [1:0] REG_START_V = 2'd3;

    // register file slots
    localparam logic [4:0] R_C0 = 5'd0;
    localparam logic [4:0] R_C1 = 5'd1;
    localparam logic [4:0] R_C2 = 5'd2;
    localparam logic [4:0] R_C3 = 5'd3;
    localparam logic [4:0] R_C4 = 5'd4;
    localparam logic [4:0] R_U = 5'd5;
    localparam logic [4:0] R_V = 5'd6;
    localparam logic [4:0] R_ONE = 5'd7;
    localparam logic [4:0] R_ZERO = 5'd8;
    localparam logic [4:0] R_P1 = 5'd9;
    localparam logic [4:0] R_P0 = 5'd10;
    localparam logic [4:0] R_R0 = 5'd11;
    localparam logic [4:0] R_R1 = 5'd12;
    localparam logic [4:0] R_R0V = 5'd13;
    localparam logic [4:0] R_R1V = 5'd14;
    localparam logic [4:0] R_R0U = 5'd15;
    localparam logic [4:0] R_R1U = 5'd16;
    localparam logic [4:0] R_DENV = 5'd17;
    localparam logic [4:0] R_DENU = 5'd18;
    localparam logic [4:0] R_T1 = 5'd19;
    localparam logic [4:0] R_T2 = 5'd20;
    localparam logic [4:0] R_DU = 5'd21;
    localparam logic [4:0] R_DV = 5'd22;
    localparam logic [4:0] R_TA = 5'd23;
    localparam logic [4:0] R_TT = 5'd24;
    localparam logic [4:0] R_DISC = 5'd25;
    localparam logic [4:0] R_M = 5'd26;
    localparam logic [4:0] R_N = 5'd27;
    localparam logic [4:0] R_S = 5'd28;

    // result slots sit above the register file
    localparam logic [5:0] OUT_A = 6'd32;
    localparam logic [5:0] OUT_B = 6'd36;

    // program landmarks
    localparam logic [6:0] PC_LOOP = 7'd9;
    localparam logic [6:0] PC_QA = 7'd46;
    localparam logic [6:0] PC_QB = 7'd70;
    localparam logic [6:0] PC_END = 7'd94;
    localparam logic [6:0] PC_NC = 7'd95;
    localparam logic [6:0] PC_ZD = 7'd96;
    localparam logic [6:0] QUAD_LEN = 7'd24;

    typedef enum logic [3:0] {
        OP_LD     = 4'd0,
        OP_ADD    = 4'd1,
        OP_SUB    = 4'd2,
        OP_MUL    = 4'd3,
        OP_DIV    = 4'd4,
        OP_SQRT   = 4'd5,
        OP_JZ2    = 4'd6,
        OP_JNEG   = 4'd7,
        OP_JMP    = 4'd8,
        OP_CHK    = 4'd9,
        OP_TEST   = 4'd10,
        OP_FIN_OK = 4'd11,
        OP_FIN_NC = 4'd12,
        OP_FIN_ZD = 4'd13
    } op_t;

    typedef struct packed {
        op_t        op;
        logic [4:0] ra;
        logic [4:0] rb;
        logic [5:0] dst;
        logic [6:0] tgt;
    } row_t;

    typedef struct packed {
        logic [31:0] tol;
        logic [7:0]  max_it;
        logic [63:0] start_u;
        logic [63:0] start_v;
    } cfg_t;

    typedef struct packed {
        logic        start;
        logic [63:0] a;
        logic [63:0] b;
    } unit_req_t;

    typedef struct packed {
        logic        done;
        logic [63:0] y;
    } unit_rsp_t;

    function automatic logic [63:0] mag(input logic [63:0] a);
        return a[63] ? (~a + 64'd1) : a;
    endfunction

    // sign and saturate a wide magnitude into a word
    function automatic logic [63:0] pack(input logic neg, input logic [95:0] m);
        logic [63:0] limit;
        logic [63:0] v;
        limit = neg ? WMIN : WMAX;
        v = ((|m[95:64]) || (m[63:0] > limit)) ? limit : m[63:0];
        return neg ? (~v + 64'd1) : v;
    endfunction

    function automatic logic [63:0] sat_addsub(input logic [63:0] a, input logic [63:0] b,
                                               input logic sub);
        logic [64:0] s;
        s = sub ? ({a[63], a} - {b[63], b}) : ({a[63], a} + {b[63], b});
        if (s[64] != s[63])
            return s[64] ? WMIN : WMAX;
        return s[63:0];
    endfunction

    function automatic row_t mk(input op_t op, input logic [4:0] ra, input logic [4:0] rb,
                                input logic [5:0] dst, input logic [6:0] tgt);
        row_t r;
        r.op = op;
        r.ra = ra;
        r.rb = rb;
        r.dst = dst;
        r.tgt = tgt;
        return r;
    endfunction

    function automatic logic [5:0] rd(input logic [4:0] r);
        return {1'b0, r};
    endfunction

    // roots of a*x^2+b*x+c into four result slots
    function automatic row_t quad_row(input logic [4:0] k, input logic [4:0] a,
                                      input logic [4:0] b, input logic [4:0] c,
                                      input logic [5:0] o, input logic [6:0] base);
        row_t r;
        case (k)
            5'd0:  r = mk(OP_ADD, a, a, rd(R_TA), 7'd0);
            5'd1:  r = mk(OP_JZ2, R_TA, R_TA, 6'd0, PC_ZD);
            5'd2:  r = mk(OP_MUL, a, c, rd(R_TT), 7'd0);
            5'd3:  r = mk(OP_ADD, R_TT, R_TT, rd(R_TT), 7'd0);
            5'd4:  r = mk(OP_ADD, R_TT, R_TT, rd(R_TT), 7'd0);
            5'd5:  r = mk(OP_MUL, b, b, rd(R_T1), 7'd0);
            5'd6:  r = mk(OP_SUB, R_T1, R_TT, rd(R_DISC), 7'd0);
            5'd7:  r = mk(OP_SUB, R_ZERO, b, rd(R_T1), 7'd0);
            5'd8:  r = mk(OP_DIV, R_T1, R_TA, rd(R_M), 7'd0);
            5'd9:  r = mk(OP_JNEG, R_DISC, R_DISC, 6'd0, base + 7'd17);
            5'd10: r = mk(OP_SQRT, R_DISC, R_DISC, rd(R_S), 7'd0);
            5'd11: r = mk(OP_DIV, R_S, R_TA, rd(R_N), 7'd0);
            5'd12: r = mk(OP_ADD, R_M, R_N, o, 7'd0);
            5'd13: r = mk(OP_ADD, R_ZERO, R_ZERO, o + 6'd1, 7'd0);
            5'd14: r = mk(OP_SUB, R_M, R_N, o + 6'd2, 7'd0);
            5'd15: r = mk(OP_ADD, R_ZERO, R_ZERO, o + 6'd3, 7'd0);
            5'd16: r = mk(OP_JMP, R_ZERO, R_ZERO, 6'd0, base + QUAD_LEN);
            5'd17: r = mk(OP_SUB, R_ZERO, R_DISC, rd(R_T1), 7'd0);
            5'd18: r = mk(OP_SQRT, R_T1, R_T1, rd(R_S), 7'd0);
            5'd19: r = mk(OP_DIV, R_S, R_TA, rd(R_N), 7'd0);
            5'd20: r = mk(OP_ADD, R_M, R_ZERO, o, 7'd0);
            5'd21: r = mk(OP_ADD, R_N, R_ZERO, o + 6'd1, 7'd0);
            5'd22: r = mk(OP_ADD, R_M, R_ZERO, o + 6'd2, 7'd0);
            5'd23: r = mk(OP_SUB, R_ZERO, R_N, o + 6'd3, 7'd0);
            default: r = mk(OP_FIN_ZD, R_ZERO, R_ZERO, 6'd0, 7'd0);
        endcase
        return r;
    endfunction

    // sequencer program: load, the iteration loop, two quadratics, finish
    function automatic row_t prog_row(input logic [6:0] pc);
        row_t r;
        logic [6:0] ka;
        logic [6:0] kb;
        ka = pc - PC_QA;
        kb = pc - PC_QB;
        if (pc < PC_LOOP)
            r = mk(OP_LD, pc[4:0], pc[4:0], rd(pc[4:0]), 7'd0);
        else if (pc >= PC_QA && pc < PC_QB)
            r = quad_row(ka[4:0], R_ONE, R_U, R_V, OUT_A, PC_QA);
        else if (pc >= PC_QB && pc < PC_END)
            r = quad_row(kb[4:0], R_C4, R_P1, R_P0, OUT_B, PC_QB);
        else begin
            case (pc)
                7'd9:  r = mk(OP_CHK, R_ZERO, R_ZERO, 6'd0, PC_NC);
                7'd10: r = mk(OP_MUL, R_U, R_C4, rd(R_T1), 7'd0);
                7'd11: r = mk(OP_SUB, R_C3, R_T1, rd(R_P1), 7'd0);
                7'd12: r = mk(OP_MUL, R_V, R_C4, rd(R_T1), 7'd0);
                7'd13: r = mk(OP_SUB, R_C2, R_T1, rd(R_T1), 7'd0);
                7'd14: r = mk(OP_MUL, R_U, R_P1, rd(R_T2), 7'd0);
                7'd15: r = mk(OP_SUB, R_T1, R_T2, rd(R_P0), 7'd0);
                7'd16: r = mk(OP_MUL, R_V, R_P1, rd(R_T1), 7'd0);
                7'd17: r = mk(OP_SUB, R_C1, R_T1, rd(R_T1), 7'd0);
                7'd18: r = mk(OP_MUL, R_U, R_P0, rd(R_T2), 7'd0);
                7'd19: r = mk(OP_SUB, R_T1, R_T2, rd(R_R0), 7'd0);
                7'd20: r = mk(OP_MUL, R_V, R_P0, rd(R_T1), 7'd0);
                7'd21: r = mk(OP_SUB, R_C0, R_T1, rd(R_R1), 7'd0);
                7'd22: r = mk(OP_MUL, R_U, R_C4, rd(R_T1), 7'd0);
                7'd23: r = mk(OP_SUB, R_T1, R_P1, rd(R_R0V), 7'd0);
                7'd24: r = mk(OP_MUL, R_V, R_C4, rd(R_T1), 7'd0);
                7'd25: r = mk(OP_SUB, R_T1, R_P0, rd(R_R1V), 7'd0);
                7'd26: r = mk(OP_MUL, R_U, R_R0V, rd(R_T1), 7'd0);
                7'd27: r = mk(OP_SUB, R_R1V, R_T1, rd(R_R0U), 7'd0);
                7'd28: r = mk(OP_MUL, R_V, R_R0V, rd(R_T1), 7'd0);
                7'd29: r = mk(OP_SUB, R_ZERO, R_T1, rd(R_R1U), 7'd0);
                7'd30: r = mk(OP_MUL, R_R0V, R_R1U, rd(R_T1), 7'd0);
                7'd31: r = mk(OP_MUL, R_R0U, R_R1V, rd(R_T2), 7'd0);
                7'd32: r = mk(OP_SUB, R_T1, R_T2, rd(R_DENV), 7'd0);
                7'd33: r = mk(OP_SUB, R_T2, R_T1, rd(R_DENU), 7'd0);
                7'd34: r = mk(OP_JZ2, R_DENV, R_DENU, 6'd0, PC_ZD);
                7'd35: r = mk(OP_MUL, R_R0U, R_R1, rd(R_T1), 7'd0);
                7'd36: r = mk(OP_MUL, R_R0, R_R1U, rd(R_T2), 7'd0);
                7'd37: r = mk(OP_SUB, R_T1, R_T2, rd(R_T1), 7'd0);
                7'd38: r = mk(OP_DIV, R_T1, R_DENV, rd(R_DV), 7'd0);
                7'd39: r = mk(OP_MUL, R_R0V, R_R1, rd(R_T1), 7'd0);
                7'd40: r = mk(OP_MUL, R_R0, R_R1V, rd(R_T2), 7'd0);
                7'd41: r = mk(OP_SUB, R_T1, R_T2, rd(R_T1), 7'd0);
                7'd42: r = mk(OP_DIV, R_T1, R_DENU, rd(R_DU), 7'd0);
                7'd43: r = mk(OP_ADD, R_U, R_DU, rd(R_U), 7'd0);
                7'd44: r = mk(OP_ADD, R_V, R_DV, rd(R_V), 7'd0);
                7'd45: r = mk(OP_TEST, R_DU, R_DV, 6'd0, PC_QA);
                7'd94: r = mk(OP_FIN_OK, R_ZERO, R_ZERO, 6'd0, 7'd0);
                7'd95: r = mk(OP_FIN_NC, R_ZERO, R_ZERO, 6'd0, 7'd0);
                default: r = mk(OP_FIN_ZD, R_ZERO, R_ZERO, 6'd0, 7'd0);
            endcase
        end
        return r;
    endfunction

endpackage

[rtl/quartic_root_solver.sv]
// Quartic root finder by Bairstow iteration, signed Q32.32 throughout.
// Input channel: in_valid/in_ready with the five coefficients coef_x0..coef_x4.
// Output channel: out_valid/out_ready with four complex roots and status
// (0 converged, 1 no convergence, 2 zero divisor).
// Configuration: APB-style port, 64 bit registers at byte addresses 0, 8, 16, 24
// (tolerance, max_iterations, start_linear, start_constant); pready is always high.
// One word is worked on at a time by a microcoded sequencer over a 32 entry
// register file and three shared units: a 4-step 32x32 multiplier, a bit-serial
// divider and a two-bit-per-step square root.
// Each iteration issues 16 multiplies and two divides; loading comes before the
// iterations, and the two quadratics follow them.
// in_ready is high only while the block is idle.
// A finished word waits in the output register; the next word is accepted while it
// waits, and a stalled receiver holds only the hand-off of the following result.
// Reset restores the register defaults and empties the output register.
module quartic_root_solver (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        psel,
    input  logic        penable,
    input  logic        pwrite,
    input  logic [4:0]  paddr,
    input  logic [63:0] pwdata,
    output logic [63:0] prdata,
    output logic        pready,
    input  logic        in_valid,
    output logic        in_ready,
    input  logic [63:0] coef_x0,
    input  logic [63:0] coef_x1,
    input  logic [63:0] coef_x2,
    input  logic [63:0] coef_x3,
    input  logic [63:0] coef_x4,
    output logic        out_valid,
    input  logic        out_ready,
    output logic [63:0] root1_re,
    output logic [63:0] root1_im,
    output logic [63:0] root2_re,
    output logic [63:0] root2_im,
    output logic [63:0] root3_re,
    output logic [63:0] root3_im,
    output logic [63:0] root4_re,
    output logic [63:0] root4_im,
    output logic [1:0]  status
);

    qrs_pkg::cfg_t      cfg_reg;
    qrs_pkg::unit_req_t mul_req, div_req, sqrt_req;
    qrs_pkg::unit_rsp_t mul_rsp, div_rsp, sqrt_rsp;
    logic [7:0][63:0]   root;
    logic [4:0][63:0]   coef;
    logic               wr_en;

    assign pready = 1'b1;
    assign wr_en = psel && penable && pwrite && pready;

    // configuration registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.tol <= 32'd43;
            cfg_reg.max_it <= 8'd50;
            cfg_reg.start_u <= 64'hffff_fffe_0000_0000;
            cfg_reg.start_v <= qrs_pkg::ONE_Q;
        end
        else if (wr_en)
        begin
            unique case (paddr[4:3])
                qrs_pkg::REG_TOL:     cfg_reg.tol <= pwdata[31:0];
                qrs_pkg::REG_MAXIT:   cfg_reg.max_it <= pwdata[7:0];
                qrs_pkg::REG_START_U: cfg_reg.start_u <= pwdata;
                qrs_pkg::REG_START_V: cfg_reg.start_v <= pwdata;
                default: ;
            endcase
        end
    end

    // register read back
    always_comb
    begin
        unique case (paddr[4:3])
            qrs_pkg::REG_TOL:     prdata = {32'd0, cfg_reg.tol};
            qrs_pkg::REG_MAXIT:   prdata = {56'd0, cfg_reg.max_it};
            qrs_pkg::REG_START_U: prdata = cfg_reg.start_u;
            qrs_pkg::REG_START_V: prdata = cfg_reg.start_v;
            default:              prdata = 64'd0;
        endcase
    end

    assign coef = {coef_x4, coef_x3, coef_x2, coef_x1, coef_x0};

    qrs_seq u_seq (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_valid),
        .in_ready  (in_ready),
        .coef      (coef),
        .cfg       (cfg_reg),
        .out_valid (out_valid),
        .out_ready (out_ready),
        .root      (root),
        .status    (status),
        .mul_req   (mul_req),
        .mul_rsp   (mul_rsp),
        .div_req   (div_req),
        .div_rsp   (div_rsp),
        .sqrt_req  (sqrt_req),
        .sqrt_rsp  (sqrt_rsp)
    );

    qrs_mul u_mul (
        .clk   (clk),
        .rst_n (rst_n),
        .req   (mul_req),
        .rsp   (mul_rsp)
    );

    qrs_div u_div (
        .clk   (clk),
        .rst_n (rst_n),
        .req   (div_req),
        .rsp   (div_rsp)
    );

    qrs_sqrt u_sqrt (
        .clk   (clk),
        .rst_n (rst_n),
        .req   (sqrt_req),
        .rsp   (sqrt_rsp)
    );

    assign root1_re = root[0];
    assign root1_im = root[1];
    assign root2_re = root[2];
    assign root2_im = root[3];
    assign root3_re = root[4];
    assign root3_im = root[5];
    assign root4_re = root[6];
    assign root4_im = root[7];

endmodule

[rtl/qrs_mul.sv]
module qrs_mul (
    input  logic                clk,
    input  logic                rst_n,
    input  qrs_pkg::unit_req_t  req,
    output qrs_pkg::unit_rsp_t  rsp
);

    localparam logic [2:0] LAST = 3'd5;
    localparam logic [2:0] MUL_STEPS = 3'd4;

    logic         busy_reg;
    logic [2:0]   cnt_reg;
    logic [63:0]  ma_reg;
    logic [63:0]  mb_reg;
    logic         neg_reg;
    logic [63:0]  prod_reg;
    logic [1:0]   sh_reg;
    logic [127:0] acc_reg;
    logic [31:0]  pa;
    logic [31:0]  pb;

    // pick the 32 bit halves for this partial product
    assign pa = cnt_reg[1] ? ma_reg[63:32] : ma_reg[31:0];
    assign pb = cnt_reg[0] ? mb_reg[63:32] : mb_reg[31:0];

    // step control
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            cnt_reg <= 3'd0;
        end
        else if (req.start)
        begin
            busy_reg <= 1'b1;
            cnt_reg <= 3'd0;
        end
        else if (busy_reg)
        begin
            cnt_reg <= cnt_reg + 3'd1;
            if (cnt_reg == LAST)
                busy_reg <= 1'b0;
        end
    end

    // partial products, registered, then accumulated
    always_ff @(posedge clk)
    begin
        if (req.start)
        begin
            ma_reg <= qrs_pkg::mag(req.a);
            mb_reg <= qrs_pkg::mag(req.b);
            neg_reg <= req.a[63] ^ req.b[63];
            acc_reg <= 128'd0;
        end
        else if (busy_reg)
        begin
            if (cnt_reg < MUL_STEPS)
            begin
                prod_reg <= pa * pb;
                sh_reg <= {1'b0, cnt_reg[1]} + {1'b0, cnt_reg[0]};
            end
            if (cnt_reg != 3'd0 && cnt_reg != LAST)
                acc_reg <= acc_reg + ({64'd0, prod_reg} << {sh_reg, 5'd0});
        end
    end

    assign rsp.done = busy_reg && (cnt_reg == LAST);
    assign rsp.y = qrs_pkg::pack(neg_reg, acc_reg[127:32]);

endmodule

[rtl/qrs_div.sv]
module qrs_div (
    input  logic                clk,
    input  logic                rst_n,
    input  qrs_pkg::unit_req_t  req,
    output qrs_pkg::unit_rsp_t  rsp
);

    localparam logic [6:0] STEPS = 7'd96;

    logic        busy_reg;
    logic [6:0]  cnt_reg;
    logic [95:0] num_reg;
    logic [95:0] q_reg;
    logic [63:0] r_reg;
    logic [63:0] d_reg;
    logic        neg_reg;
    logic [64:0] r2;
    logic        fits;

    // restoring step, one quotient bit
    assign r2 = {r_reg, num_reg[95]};
    assign fits = r2 >= {1'b0, d_reg};

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            cnt_reg <= 7'd0;
        end
        else if (req.start)
        begin
            busy_reg <= 1'b1;
            cnt_reg <= 7'd0;
        end
        else if (busy_reg)
        begin
            if (cnt_reg == STEPS)
                busy_reg <= 1'b0;
            else
                cnt_reg <= cnt_reg + 7'd1;
        end
    end

    always_ff @(posedge clk)
    begin
        if (req.start)
        begin
            num_reg <= {qrs_pkg::mag(req.a), 32'd0};
            d_reg <= qrs_pkg::mag(req.b);
            neg_reg <= req.a[63] ^ req.b[63];
            r_reg <= 64'd0;
            q_reg <= 96'd0;
        end
        else if (busy_reg && cnt_reg != STEPS)
        begin
            num_reg <= {num_reg[94:0], 1'b0};
            q_reg <= {q_reg[94:0], fits};
            r_reg <= fits ? 64'(r2 - {1'b0, d_reg}) : r2[63:0];
        end
    end

    assign rsp.done = busy_reg && (cnt_reg == STEPS);
    assign rsp.y = qrs_pkg::pack(neg_reg, q_reg);

endmodule

[rtl/qrs_sqrt.sv]
module qrs_sqrt (
    input  logic                clk,
    input  logic                rst_n,
    input  qrs_pkg::unit_req_t  req,
    output qrs_pkg::unit_rsp_t  rsp
);

    localparam logic [5:0] STEPS = 6'd48;

    logic        busy_reg;
    logic [5:0]  cnt_reg;
    logic [95:0] x_reg;
    logic [49:0] rem_reg;
    logic [47:0] root_reg;
    logic [51:0] rem2;
    logic [51:0] trial;
    logic        fits;

    // two radicand bits per step
    assign rem2 = {rem_reg, x_reg[95:94]};
    assign trial = {2'b00, root_reg, 2'b01};
    assign fits = rem2 >= trial;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            cnt_reg <= 6'd0;
        end
        else if (req.start)
        begin
            busy_reg <= 1'b1;
            cnt_reg <= 6'd0;
        end
        else if (busy_reg)
        begin
            if (cnt_reg == STEPS)
                busy_reg <= 1'b0;
            else
                cnt_reg <= cnt_reg + 6'd1;
        end
    end

    always_ff @(posedge clk)
    begin
        if (req.start)
        begin
            x_reg <= {qrs_pkg::mag(req.a), 32'd0};
            rem_reg <= 50'd0;
            root_reg <= 48'd0;
        end
        else if (busy_reg && cnt_reg != STEPS)
        begin
            x_reg <= {x_reg[93:0], 2'b00};
            rem_reg <= fits ? 50'(rem2 - trial) : rem2[49:0];
            root_reg <= {root_reg[46:0], fits};
        end
    end

    assign rsp.done = busy_reg && (cnt_reg == STEPS);
    assign rsp.y = {16'd0, root_reg};

endmodule

[rtl/qrs_seq.sv]
module qrs_seq (
    input  logic                clk,
    input  logic                rst_n,
    input  logic                in_valid,
    output logic                in_ready,
    input  logic [4:0][63:0]    coef,
    input  qrs_pkg::cfg_t       cfg,
    output logic                out_valid,
    input  logic                out_ready,
    output logic [7:0][63:0]    root,
    output logic [1:0]          status,
    output qrs_pkg::unit_req_t  mul_req,
    input  qrs_pkg::unit_rsp_t  mul_rsp,
    output qrs_pkg::unit_req_t  div_req,
    input  qrs_pkg::unit_rsp_t  div_rsp,
    output qrs_pkg::unit_req_t  sqrt_req,
    input  qrs_pkg::unit_rsp_t  sqrt_rsp
);

    typedef enum logic [4:0] {
        S_IDLE  = 5'b00001,
        S_FETCH = 5'b00010,
        S_EXEC  = 5'b00100,
        S_WAIT  = 5'b01000,
        S_DONE  = 5'b10000
    } seq_state_t;

    seq_state_t       state_reg, state_next;
    logic [6:0]       pc_reg, pc_next;
    logic [7:0]       it_reg, it_next;
    logic [1:0]       st_reg, st_next;
    logic [4:0][63:0] coef_reg;
    logic [63:0]      mem [32];
    logic [63:0]      rd_a_reg;
    logic [63:0]      rd_b_reg;
    logic [7:0][63:0] res_reg;
    logic [7:0][63:0] root_reg;
    logic [1:0]       status_reg;
    logic             out_valid_reg;
    qrs_pkg::row_t    row;
    logic             we;
    logic [63:0]      wdata;
    logic [63:0]      ld_val;
    logic [63:0]      addsub;
    logic             unit_done;
    logic [63:0]      unit_y;
    logic             mul_go;
    logic             div_go;
    logic             sqrt_go;
    logic             conv;
    logic             hand_off;

    assign row = qrs_pkg::prog_row(pc_reg);
    assign in_ready = (state_reg == S_IDLE);
    assign hand_off = (state_reg == S_DONE) && (!out_valid_reg || out_ready);

    // operand sources
    always_comb
    begin
        case (row.ra)
            qrs_pkg::R_C0:  ld_val = coef_reg[0];
            qrs_pkg::R_C1:  ld_val = coef_reg[1];
            qrs_pkg::R_C2:  ld_val = coef_reg[2];
            qrs_pkg::R_C3:  ld_val = coef_reg[3];
            qrs_pkg::R_C4:  ld_val = coef_reg[4];
            qrs_pkg::R_U:   ld_val = cfg.start_u;
            qrs_pkg::R_V:   ld_val = cfg.start_v;
            qrs_pkg::R_ONE: ld_val = qrs_pkg::ONE_Q;
            default:        ld_val = 64'd0;
        endcase
    end

    assign addsub = qrs_pkg::sat_addsub(rd_a_reg, rd_b_reg, row.op == qrs_pkg::OP_SUB);
    assign conv = (qrs_pkg::mag(rd_a_reg) < {32'd0, cfg.tol}) &&
                  (qrs_pkg::mag(rd_b_reg) < {32'd0, cfg.tol});

    // result of the unit in use
    always_comb
    begin
        case (row.op)
            qrs_pkg::OP_MUL:
            begin
                unit_done = mul_rsp.done;
                unit_y = mul_rsp.y;
            end
            qrs_pkg::OP_DIV:
            begin
                unit_done = div_rsp.done;
                unit_y = div_rsp.y;
            end
            default:
            begin
                unit_done = sqrt_rsp.done;
                unit_y = sqrt_rsp.y;
            end
        endcase
    end

    // sequencer
    always_comb
    begin
        state_next = state_reg;
        pc_next = pc_reg;
        it_next = it_reg;
        st_next = st_reg;
        we = 1'b0;
        wdata = addsub;
        mul_go = 1'b0;
        div_go = 1'b0;
        sqrt_go = 1'b0;
        unique case (state_reg)
            S_IDLE:
            begin
                if (in_valid)
                begin
                    state_next = S_FETCH;
                    pc_next = 7'd0;
                    it_next = 8'd0;
                end
            end
            S_FETCH:
                state_next = S_EXEC;
            S_EXEC:
            begin
                state_next = S_FETCH;
                pc_next = pc_reg + 7'd1;
                case (row.op) inside
                    qrs_pkg::OP_LD:
                    begin
                        we = 1'b1;
                        wdata = ld_val;
                    end
                    qrs_pkg::OP_ADD, qrs_pkg::OP_SUB:
                        we = 1'b1;
                    qrs_pkg::OP_MUL:
                    begin
                        mul_go = 1'b1;
                        state_next = S_WAIT;
                        pc_next = pc_reg;
                    end
                    qrs_pkg::OP_DIV:
                    begin
                        div_go = 1'b1;
                        state_next = S_WAIT;
                        pc_next = pc_reg;
                    end
                    qrs_pkg::OP_SQRT:
                    begin
                        sqrt_go = 1'b1;
                        state_next = S_WAIT;
                        pc_next = pc_reg;
                    end
                    qrs_pkg::OP_JZ2:
                        if (rd_a_reg == 64'd0 || rd_b_reg == 64'd0)
                            pc_next = row.tgt;
                    qrs_pkg::OP_JNEG:
                        if (rd_a_reg[63])
                            pc_next = row.tgt;
                    qrs_pkg::OP_JMP:
                        pc_next = row.tgt;
                    qrs_pkg::OP_CHK:
                        if (it_reg >= cfg.max_it)
                            pc_next = row.tgt;
                    qrs_pkg::OP_TEST:
                    begin
                        if (conv)
                            pc_next = row.tgt;
                        else
                        begin
                            it_next = it_reg + 8'd1;
                            pc_next = qrs_pkg::PC_LOOP;
                        end
                    end
                    qrs_pkg::OP_FIN_OK:
                    begin
                        st_next = qrs_pkg::ST_OK;
                        state_next = S_DONE;
                    end
                    qrs_pkg::OP_FIN_NC:
                    begin
                        st_next = qrs_pkg::ST_NC;
                        state_next = S_DONE;
                    end
                    default:
                    begin
                        st_next = qrs_pkg::ST_ZD;
                        state_next = S_DONE;
                    end
                endcase
            end
            S_WAIT:
            begin
                if (unit_done)
                begin
                    we = 1'b1;
                    wdata = unit_y;
                    pc_next = pc_reg + 7'd1;
                    state_next = S_FETCH;
                end
            end
            S_DONE:
                if (hand_off)
                    state_next = S_IDLE;
            default:
                state_next = S_IDLE;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_IDLE;
            pc_reg <= 7'd0;
            it_reg <= 8'd0;
            st_reg <= qrs_pkg::ST_OK;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            pc_reg <= pc_next;
            it_reg <= it_next;
            st_reg <= st_next;
            if (hand_off)
                out_valid_reg <= 1'b1;
            else if (out_ready)
                out_valid_reg <= 1'b0;
        end
    end

    // register file, registered reads
    always_ff @(posedge clk)
    begin
        if (we && !row.dst[5])
            mem[row.dst[4:0]] <= wdata;
        if (state_reg == S_FETCH)
        begin
            rd_a_reg <= mem[row.ra];
            rd_b_reg <= mem[row.rb];
        end
    end

    // input word capture, root slots and output word
    always_ff @(posedge clk)
    begin
        if (state_reg == S_IDLE && in_valid)
            coef_reg <= coef;
        if (we && row.dst[5])
            res_reg[row.dst[2:0]] <= wdata;
        if (hand_off)
        begin
            status_reg <= st_reg;
            for (int i = 0; i < 8; i++)
            begin
                if (st_reg == qrs_pkg::ST_OK)
                    root_reg[i] <= res_reg[i];
                else if (st_reg == qrs_pkg::ST_ZD)
                    root_reg[i] <= qrs_pkg::WMAX;
                else
                    root_reg[i] <= 64'd0;
            end
        end
    end

    assign mul_req = '{start: mul_go, a: rd_a_reg, b: rd_b_reg};
    assign div_req = '{start: div_go, a: rd_a_reg, b: rd_b_reg};
    assign sqrt_req = '{start: sqrt_go, a: rd_a_reg, b: rd_b_reg};

    assign out_valid = out_valid_reg;
    assign root = root_reg;
    assign status = status_reg;

endmodule

[rtl/qrs_checker.sv]
module qrs_checker (
    input logic        clk,
    input logic        rst_n,
    input logic        in_valid,
    input logic        in_ready,
    input logic        out_valid,
    input logic        out_ready,
    input logic [1:0]  status,
    input logic [63:0] root1_re,
    input logic [63:0] root4_im
);

    // a word in flight keeps the input closed
    a_busy_after_accept: assert property (@(posedge clk) disable iff (!rst_n)
        in_valid && in_ready |=> !in_ready)
        else $error("input accepted again right after an accept");

    // status is one of the three codes
    a_status_code: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid |-> (status == qrs_pkg::ST_OK || status == qrs_pkg::ST_NC ||
                       status == qrs_pkg::ST_ZD))
        else $error("bad status code");

    // no convergence clears the roots
    a_nc_zero: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && status == qrs_pkg::ST_NC |-> root1_re == 64'd0 && root4_im == 64'd0)
        else $error("roots not cleared on no convergence");

    // zero divisor saturates the roots
    a_zd_max: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && status == qrs_pkg::ST_ZD |->
            root1_re == qrs_pkg::WMAX && root4_im == qrs_pkg::WMAX)
        else $error("roots not saturated on zero divisor");

    // stalled result holds
    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !out_ready |=> out_valid && $stable(root1_re) && $stable(status))
        else $error("result changed while stalled");

endmodule

bind quartic_root_solver qrs_checker u_qrs_checker (.*);

[dv/tb_quartic_root_solver.sv]
`timescale 1ns / 100ps

module tb_quartic_root_solver;

    typedef struct {
        logic [63:0] root [8];
        logic [1:0]  st;
    } root_word_t;

    // bit-exact prediction of the root finder and the queue of pending root words
    class root_scoreboard;
        logic [31:0] tol;
        logic [7:0]  max_it;
        longint      start_u;
        longint      start_v;
        root_word_t  pending [$];
        int          errors;

        function new();
            tol = 32'd43;
            max_it = 8'd50;
            start_u = -(64'sd2 <<< 32);
            start_v = 64'sd1 <<< 32;
            errors = 0;
        endfunction

        function bit [63:0] mag(longint a);
            return a < 0 ? 64'd0 - a : a;
        endfunction

        function longint pack(bit neg, bit [127:0] m);
            bit [63:0] lim;
            bit [63:0] v;
            lim = neg ? qrs_pkg::WMIN : qrs_pkg::WMAX;
            v = (m > {64'd0, lim}) ? lim : m[63:0];
            return neg ? 64'd0 - v : v;
        endfunction

        function longint q_add(longint a, longint b);
            logic signed [64:0] s;
            s = $signed({a[63], a}) + $signed({b[63], b});
            if (s[64] != s[63])
                return s[64] ? qrs_pkg::WMIN : qrs_pkg::WMAX;
            return s[63:0];
        endfunction

        function longint q_sub(longint a, longint b);
            logic signed [64:0] s;
            s = $signed({a[63], a}) - $signed({b[63], b});
            if (s[64] != s[63])
                return s[64] ? qrs_pkg::WMIN : qrs_pkg::WMAX;
            return s[63:0];
        endfunction

        function longint q_mul(longint a, longint b);
            bit [127:0] p;
            p = {64'd0, mag(a)} * {64'd0, mag(b)};
            return pack((a < 0) != (b < 0), p >> 32);
        endfunction

        function longint q_div(longint a, longint b);
            bit [127:0] n;
            n = {64'd0, mag(a)} << 32;
            return pack((a < 0) != (b < 0), n / {64'd0, mag(b)});
        endfunction

        function longint q_sqrt(longint a);
            bit [127:0] x;
            bit [63:0]  r;
            bit [63:0]  c;
            x = {64'd0, mag(a)} << 32;
            r = 0;
            for (int i = 63; i >= 0; i--)
            begin
                c = r | (64'd1 << i);
                if ({64'd0, c} * {64'd0, c} <= x)
                    r = c;
            end
            return pack(1'b0, {64'd0, r});
        endfunction

        // roots of a*x^2+b*x+c, zero when the leading term vanishes
        function bit solve_quadratic(longint a, longint b, longint c, output longint o [4]);
            longint two_a, t, disc, m, n;
            two_a = q_add(a, a);
            o = '{0, 0, 0, 0};
            if (two_a == 0)
                return 1'b0;
            t = q_mul(a, c);
            t = q_add(t, t);
            t = q_add(t, t);
            disc = q_sub(q_mul(b, b), t);
            m = q_div(q_sub(0, b), two_a);
            if (disc >= 0)
            begin
                n = q_div(q_sqrt(disc), two_a);
                o = '{q_add(m, n), 0, q_sub(m, n), 0};
            end
            else
            begin
                n = q_div(q_sqrt(q_sub(0, disc)), two_a);
                o = '{m, n, m, q_sub(0, n)};
            end
            return 1'b1;
        endfunction

        // bairstow iteration on one accepted quartic
        function void note_quartic(longint c0, longint c1, longint c2, longint c3,
                                   longint c4);
            longint u, v, p1, p0, r0, r1, r0v, r1v, r0u, r1u, den_v, den_u, du, dv;
            longint ra [4];
            longint rb [4];
            logic [1:0] st;
            root_word_t w;
            u = start_u;
            v = start_v;
            st = qrs_pkg::ST_NC;
            ra = '{0, 0, 0, 0};
            rb = '{0, 0, 0, 0};
            for (int it = 0; it < max_it; it++)
            begin
                p1 = q_sub(c3, q_mul(u, c4));
                p0 = q_sub(q_sub(c2, q_mul(v, c4)), q_mul(u, p1));
                r0 = q_sub(q_sub(c1, q_mul(v, p1)), q_mul(u, p0));
                r1 = q_sub(c0, q_mul(v, p0));
                r0v = q_sub(q_mul(u, c4), p1);
                r1v = q_sub(q_mul(v, c4), p0);
                r0u = q_sub(r1v, q_mul(u, r0v));
                r1u = q_sub(0, q_mul(v, r0v));
                den_v = q_sub(q_mul(r0v, r1u), q_mul(r0u, r1v));
                den_u = q_sub(q_mul(r0u, r1v), q_mul(r0v, r1u));
                if (den_v == 0 || den_u == 0)
                begin
                    st = qrs_pkg::ST_ZD;
                    break;
                end
                dv = q_div(q_sub(q_mul(r0u, r1), q_mul(r0, r1u)), den_v);
                du = q_div(q_sub(q_mul(r0v, r1), q_mul(r0, r1v)), den_u);
                u = q_add(u, du);
                v = q_add(v, dv);
                if (mag(du) < {32'd0, tol} && mag(dv) < {32'd0, tol})
                begin
                    if (solve_quadratic(qrs_pkg::ONE_Q, u, v, ra) &&
                        solve_quadratic(c4, p1, p0, rb))
                        st = qrs_pkg::ST_OK;
                    else
                        st = qrs_pkg::ST_ZD;
                    break;
                end
            end
            for (int j = 0; j < 8; j++)
                w.root[j] = (st == qrs_pkg::ST_OK) ? (j < 4 ? ra[j] : rb[j - 4]) :
                            (st == qrs_pkg::ST_ZD) ? qrs_pkg::WMAX : 64'd0;
            w.st = st;
            pending.push_back(w);
        endfunction

        function void check_roots(root_word_t got);
            root_word_t exp_w;
            bit bad;
            if (pending.size() == 0)
            begin
                errors++;
                if (errors <= 10)
                    $display("unexpected root word, status %0d", got.st);
                return;
            end
            exp_w = pending.pop_front();
            bad = (exp_w.st !== got.st);
            for (int j = 0; j < 8; j++)
                if (exp_w.root[j] !== got.root[j])
                    bad = 1'b1;
            if (bad)
            begin
                errors++;
                if (errors <= 10)
                begin
                    $display("root word mismatch: status exp %0d got %0d", exp_w.st, got.st);
                    for (int j = 0; j < 8; j++)
                        $display("  field %0d exp %h got %h", j, exp_w.root[j], got.root[j]);
                end
            end
        endfunction
    endclass

    logic        clk;
    logic        rst_n;
    logic        psel, penable, pwrite;
    logic [4:0]  paddr;
    logic [63:0] pwdata;
    logic [63:0] prdata;
    logic        pready;
    logic        in_valid, in_ready;
    logic [63:0] coef_x0, coef_x1, coef_x2, coef_x3, coef_x4;
    logic        out_valid, out_ready;
    logic [63:0] root1_re, root1_im, root2_re, root2_im;
    logic [63:0] root3_re, root3_im, root4_re, root4_im;
    logic [1:0]  status;

    root_scoreboard sb;
    bit no_gaps;
    bit hold_armed;
    int words_seen;

    quartic_root_solver dut (.*);

    // clock
    initial
    begin
        clk = 1'b0;
        forever #4 clk = ~clk;
    end

    // register write over the configuration port, mirrored into the predictor
    task automatic write_reg(logic [1:0] idx, logic [63:0] val);
        @(negedge clk);
        psel <= 1'b1;
        pwrite <= 1'b1;
        penable <= 1'b0;
        paddr <= {idx, 3'b000};
        pwdata <= val;
        @(negedge clk);
        penable <= 1'b1;
        @(posedge clk);
        while (!pready)
            @(posedge clk);
        case (idx)
            qrs_pkg::REG_TOL:     sb.tol = val[31:0];
            qrs_pkg::REG_MAXIT:   sb.max_it = val[7:0];
            qrs_pkg::REG_START_U: sb.start_u = val;
            qrs_pkg::REG_START_V: sb.start_v = val;
        endcase
        @(negedge clk);
        psel <= 1'b0;
        penable <= 1'b0;
        pwrite <= 1'b0;
    endtask

    task automatic set_config(logic [31:0] t, logic [7:0] m, longint su, longint sv);
        write_reg(qrs_pkg::REG_TOL, {32'd0, t});
        write_reg(qrs_pkg::REG_MAXIT, {56'd0, m});
        write_reg(qrs_pkg::REG_START_U, su);
        write_reg(qrs_pkg::REG_START_V, sv);
    endtask

    // offer one quartic and hold it until taken
    task automatic send_quartic(longint c0, longint c1, longint c2, longint c3, longint c4);
        int gap;
        gap = no_gaps ? 0 : $urandom_range(0, 19);
        if (gap > 0)
        begin
            in_valid <= 1'b0;
            repeat (gap) @(negedge clk);
        end
        in_valid <= 1'b1;
        coef_x0 <= c0;
        coef_x1 <= c1;
        coef_x2 <= c2;
        coef_x3 <= c3;
        coef_x4 <= c4;
        @(posedge clk);
        while (!in_ready)
            @(posedge clk);
        sb.note_quartic(c0, c1, c2, c3, c4);
        @(negedge clk);
    endtask

    task automatic drain();
        @(negedge clk);
        in_valid <= 1'b0;
        while (sb.pending.size() != 0)
            @(negedge clk);
        repeat (5) @(negedge clk);
    endtask

    function automatic longint rand_word();
        return {$urandom, $urandom};
    endfunction

    // small value near an integer, in q32.32
    function automatic longint near_int(int lo, int hi);
        longint r;
        r = longint'($urandom_range(0, hi - lo)) + lo;
        return (r <<< 32) + $signed({32'd0, $urandom_range(0, 4095)}) - 64'sd2048;
    endfunction

    // mostly products of a factor near the start factor and a random quadratic
    task automatic send_random();
        longint a, b, c, d, k, e, f, g;
        int pick;
        pick = $urandom_range(0, 99);
        if (pick < 70)
        begin
            a = sb.start_u + $signed({32'd0, $urandom_range(0, 1 << 22)}) - 64'sd2097152;
            b = sb.start_v + $signed({32'd0, $urandom_range(0, 1 << 22)}) - 64'sd2097152;
            c = near_int(-4, 4);
            d = near_int(-4, 4);
            k = near_int(1, 3);
            e = sb.q_add(c, a);
            f = sb.q_add(sb.q_add(d, b), sb.q_mul(a, c));
            g = sb.q_add(sb.q_mul(a, d), sb.q_mul(b, c));
            send_quartic(sb.q_mul(k, sb.q_mul(b, d)), sb.q_mul(k, g), sb.q_mul(k, f),
                         sb.q_mul(k, e), k);
        end
        else if (pick < 85)
            send_quartic(near_int(-8, 8), near_int(-8, 8), near_int(-8, 8),
                         near_int(-8, 8), near_int(-2, 2));
        else
            send_quartic(rand_word(), rand_word(), rand_word(), rand_word(), rand_word());
    endtask

    // receiver with random stalls and one long hold-off
    initial
    begin
        root_word_t got;
        int gap;
        out_ready = 1'b0;
        words_seen = 0;
        @(posedge rst_n);
        forever
        begin
            gap = no_gaps ? 0 : $urandom_range(0, 19);
            if (hold_armed && words_seen == 25)
            begin
                hold_armed = 1'b0;
                gap = 15000;
            end
            if (gap > 0)
            begin
                @(negedge clk);
                out_ready <= 1'b0;
                repeat (gap - 1) @(negedge clk);
            end
            @(negedge clk);
            out_ready <= 1'b1;
            @(posedge clk);
            while (!out_valid)
                @(posedge clk);
            got.root = '{root1_re, root1_im, root2_re, root2_im,
                         root3_re, root3_im, root4_re, root4_im};
            got.st = status;
            sb.check_roots(got);
            words_seen++;
        end
    end

    // stimulus
    initial
    begin
        sb = new();
        no_gaps = 1'b0;
        hold_armed = 1'b1;
        rst_n = 1'b0;
        psel = 1'b0;
        penable = 1'b0;
        pwrite = 1'b0;
        paddr = '0;
        pwdata = '0;
        in_valid = 1'b0;
        {coef_x0, coef_x1, coef_x2, coef_x3, coef_x4} = '0;
        repeat (10) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;

        // directed at reset settings: double root at one, complex pair, extremes
        send_quartic(64'sd1 <<< 32, -(64'sd1 <<< 32), 64'sd1 <<< 32, -(64'sd1 <<< 32),
                     64'sd1 <<< 32);
        send_quartic(64'sd2 <<< 32, -(64'sd6 <<< 32), 64'sd7 <<< 32, -(64'sd4 <<< 32),
                     64'sd1 <<< 32);
        send_quartic(64'sd1 <<< 32, 64'sd0, -(64'sd2 <<< 32), 64'sd0, 64'sd0);
        send_quartic(0, 0, 0, 0, 0);
        send_quartic(qrs_pkg::WMAX, qrs_pkg::WMAX, qrs_pkg::WMAX, qrs_pkg::WMAX,
                     qrs_pkg::WMAX);
        send_quartic(qrs_pkg::WMIN, qrs_pkg::WMIN, qrs_pkg::WMIN, qrs_pkg::WMIN,
                     qrs_pkg::WMIN);
        send_quartic(qrs_pkg::WMAX, qrs_pkg::WMIN, qrs_pkg::WMAX, qrs_pkg::WMIN,
                     qrs_pkg::WMAX);
        send_quartic(64'sd1, -64'sd1, 64'sd1, -64'sd1, 64'sd1);
        send_quartic(-(64'sd4 <<< 32), 0, 0, 0, 64'sd1 <<< 32);
        send_quartic(64'sd4 <<< 32, 0, 0, 0, 64'sd1 <<< 32);
        send_quartic(64'sd1 <<< 32, -(64'sd2 <<< 32), 64'sd1 <<< 32, 0, 0);
        drain();

        // loosest tolerance with the longest limit, then never converging
        set_config(32'hffff_ffff, 8'd255, qrs_pkg::WMIN, qrs_pkg::WMAX);
        send_quartic(64'sd1 <<< 32, -(64'sd1 <<< 32), 64'sd1 <<< 32, -(64'sd1 <<< 32),
                     64'sd1 <<< 32);
        send_quartic(qrs_pkg::WMAX, qrs_pkg::WMIN, 0, 64'sd3, qrs_pkg::WMIN);
        drain();
        set_config(32'd0, 8'd3, qrs_pkg::WMAX, qrs_pkg::WMIN);
        send_quartic(64'sd2 <<< 32, -(64'sd6 <<< 32), 64'sd7 <<< 32, -(64'sd4 <<< 32),
                     64'sd1 <<< 32);
        send_quartic(rand_word(), rand_word(), rand_word(), rand_word(), rand_word());
        drain();
        set_config(32'd1, 8'd1, -(64'sd2 <<< 32), 64'sd1 <<< 32);
        send_quartic(64'sd1 <<< 32, -(64'sd4 <<< 32), 64'sd6 <<< 32, -(64'sd4 <<< 32),
                     64'sd1 <<< 32);
        drain();

        // random phases, one of them without any idling
        for (int ph = 0; ph < 5; ph++)
        begin
            set_config((ph % 2) ? $urandom : $urandom_range(1, 1 << 20),
                       $urandom_range(1, 12), near_int(-3, 3), near_int(-3, 3));
            no_gaps = (ph == 3);
            for (int i = 0; i < 20; i++)
                send_random();
            drain();
        end

        repeat (50) @(posedge clk);
        if (sb.errors == 0)
            $display("quartic_root_solver: match");
        else
            $display("quartic_root_solver: mismatch");
        $finish;
    end

    // hang guard
    initial
    begin
        #200_000_000;
        $display("quartic_root_solver: mismatch");
        $finish;
    end

endmodule

[files.f]
rtl/qrs_pkg.sv
rtl/qrs_mul.sv
rtl/qrs_div.sv
rtl/qrs_sqrt.sv
rtl/qrs_seq.sv
rtl/quartic_root_solver.sv
rtl/qrs_checker.sv
dv/tb_quartic_root_solver.sv
